// ===== rtl/core/sts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, token kind codes and the keyword table of the token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_NUMDOT,
    MODE_DECIMAL,
    MODE_STRING,
    MODE_OPERATOR,
    MODE_COMMENT
  } scan_mode_t;

  typedef logic [5:0] kind_t;

  localparam kind_t K_NUMBER    = 6'd0;
  localparam kind_t K_DECIMAL   = 6'd1;
  localparam kind_t K_STRING    = 6'd2;
  localparam kind_t K_IDENT     = 6'd3;
  localparam kind_t K_KEYWORD0  = 6'd4;
  localparam kind_t K_ASSIGN    = 6'd24;
  localparam kind_t K_EQUALS    = 6'd25;
  localparam kind_t K_NOT_EQ    = 6'd26;
  localparam kind_t K_LT        = 6'd27;
  localparam kind_t K_GT        = 6'd28;
  localparam kind_t K_LT_EQ     = 6'd29;
  localparam kind_t K_GT_EQ     = 6'd30;
  localparam kind_t K_PLUS      = 6'd31;
  localparam kind_t K_MINUS     = 6'd32;
  localparam kind_t K_STAR      = 6'd33;
  localparam kind_t K_SLASH     = 6'd34;
  localparam kind_t K_LPAREN    = 6'd35;
  localparam kind_t K_RPAREN    = 6'd36;
  localparam kind_t K_LBRACE    = 6'd37;
  localparam kind_t K_RBRACE    = 6'd38;
  localparam kind_t K_LBRACKET  = 6'd39;
  localparam kind_t K_RBRACKET  = 6'd40;
  localparam kind_t K_COMMA     = 6'd41;
  localparam kind_t K_SEMICOLON = 6'd42;
  localparam kind_t K_NEWLINE   = 6'd43;
  localparam kind_t K_EOF       = 6'd44;
  localparam kind_t K_ERROR     = 6'd45;

  localparam int TABLE_WORDS = 20;
  localparam int MAX_TOKENS  = 3;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_BANG    = 8'h21;

  function automatic logic [71:0] kw_word(input logic [4:0] k);
    logic [71:0] w;
    case (k)
      5'd0:    w = "let";
      5'd1:    w = "is";
      5'd2:    w = "define";
      5'd3:    w = "returns";
      5'd4:    w = "give";
      5'd5:    w = "check";
      5'd6:    w = "otherwise";
      5'd7:    w = "repeat";
      5'd8:    w = "each";
      5'd9:    w = "in";
      5'd10:   w = "show";
      5'd11:   w = "true";
      5'd12:   w = "false";
      5'd13:   w = "from";
      5'd14:   w = "of";
      5'd15:   w = "nothing";
      5'd16:   w = "num";
      5'd17:   w = "decimal";
      5'd18:   w = "text";
      5'd19:   w = "bool";
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    logic [3:0] n;
    case (k)
      5'd1, 5'd9, 5'd14:                         n = 4'd2;
      5'd0, 5'd16:                               n = 4'd3;
      5'd4, 5'd8, 5'd10, 5'd11, 5'd13, 5'd18, 5'd19: n = 4'd4;
      5'd5, 5'd12:                               n = 4'd5;
      5'd2, 5'd7:                                n = 4'd6;
      5'd3, 5'd15, 5'd17:                        n = 4'd7;
      5'd6:                                      n = 4'd9;
      default:                                   n = 4'd0;
    endcase
    return n;
  endfunction

  // character i of keyword k, counted from the first letter
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] i);
    logic [71:0] w;
    logic [3:0]  n;
    logic [3:0]  sh;
    w  = kw_word(k);
    n  = kw_len(k);
    sh = n - 4'd1 - i;
    if (i < n) begin
      return w[8*sh +: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic [7:0] note_char(input logic [1:0] i);
    logic [7:0] ch;
    case (i)
      2'd0:    ch = "n";
      2'd1:    ch = "o";
      2'd2:    ch = "t";
      default: ch = "e";
    endcase
    return ch;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] ch);
    kind_t k;
    case (ch)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "[":     k = K_LBRACKET;
      "]":     k = K_RBRACKET;
      ",":     k = K_COMMA;
      ";":     k = K_SEMICOLON;
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      "=":     k = K_ASSIGN;
      "<":     k = K_LT;
      ">":     k = K_GT;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic kind_t pair_kind(input logic [7:0] op);
    kind_t k;
    case (op)
      CH_EQ:   k = K_EQUALS;
      CH_BANG: k = K_NOT_EQ;
      CH_LT:   k = K_LT_EQ;
      default: k = K_GT_EQ;
    endcase
    return k;
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

endpackage

// ===== rtl/core/sts_keyword_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_keyword_match
// Narrows the keyword candidate mask by one identifier byte and resolves the
// keyword, if any, that a finished identifier spells exactly.
// ----------------------------------------------------------------------------
module sts_keyword_match #(
  parameter int KEYWORD_COUNT = 20
) (
  input  logic [KEYWORD_COUNT-1:0] track_cand,
  input  logic [3:0]               track_idx,
  input  logic [7:0]               ch,
  input  logic [KEYWORD_COUNT-1:0] match_cand,
  input  logic [3:0]               match_len,
  output logic [KEYWORD_COUNT-1:0] cand_out,
  output logic                     kw_hit,
  output logic [4:0]               kw_index
);
  import sts_pkg::*;

  always_comb begin
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      if (k < TABLE_WORDS) begin
        cand_out[k] = track_cand[k] && (track_idx < kw_len(5'(k)))
                      && (kw_char(5'(k), track_idx) == ch);
      end else begin
        cand_out[k] = track_cand[k];
      end
    end
  end

  // lowest matching entry wins
  always_comb begin
    kw_hit   = 1'b0;
    kw_index = '0;
    for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
      if (k < TABLE_WORDS && match_cand[k] && match_len == kw_len(5'(k))) begin
        kw_hit   = 1'b1;
        kw_index = 5'(k);
      end
    end
  end

endmodule

// ===== rtl/core/source_token_scanner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_scanner_unit
// Streaming tokenizer: one source byte per transfer, tokens out with kind,
// start, length, line and column.
// ----------------------------------------------------------------------------
// a token is written into the token queue by the byte transfer that finishes
// it
// throughput: one byte per cycle while each byte yields at most one token and
// out_ready stays high; output is one token per cycle through a four-entry
// token queue, and input is held off until the queue has room for three tokens
// reset: scanner state idle at offset 0, line 1, column 1, queue empty
module source_token_scanner_unit #(
  parameter int POSITION_BITS = 20,
  parameter int LINE_BITS     = 16,
  parameter int KEYWORD_COUNT = 20
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               source_byte,
  input  logic                     end_of_source,
  output logic                     out_valid,
  input  logic                     out_ready,
  output sts_pkg::kind_t           token_kind,
  output logic [POSITION_BITS-1:0] token_start,
  output logic [POSITION_BITS-1:0] token_length,
  output logic [LINE_BITS-1:0]     token_line,
  output logic [LINE_BITS-1:0]     token_column,
  output logic                     last_of_run
);
  import sts_pkg::*;

  typedef struct packed {
    kind_t                    kind;
    logic [POSITION_BITS-1:0] start;
    logic [POSITION_BITS-1:0] len;
    logic [LINE_BITS-1:0]     line;
    logic [LINE_BITS-1:0]     col;
  } tok_t;

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [LINE_BITS-1:0]     LINE_ONE = LINE_BITS'(1);

  function automatic logic [POSITION_BITS-1:0] pos_inc(
      input logic [POSITION_BITS-1:0] v, input logic [1:0] d);
    logic [POSITION_BITS:0] s;
    s = {1'b0, v} + (POSITION_BITS+1)'(d);
    return s[POSITION_BITS] ? '1 : s[POSITION_BITS-1:0];
  endfunction

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
    return (&v) ? v : v + LINE_ONE;
  endfunction

  function automatic tok_t mk_tok(input kind_t k, input logic [POSITION_BITS-1:0] s,
      input logic [POSITION_BITS-1:0] l, input logic [LINE_BITS-1:0] ln,
      input logic [LINE_BITS-1:0] cl);
    tok_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.line  = ln;
    t.col   = cl;
    return t;
  endfunction

  // scanner state
  scan_mode_t               mode, mode_next;
  logic [POSITION_BITS-1:0] byte_pos, byte_pos_next;
  logic [LINE_BITS-1:0]     cur_line, cur_line_next;
  logic [LINE_BITS-1:0]     cur_col, cur_col_next;
  logic [POSITION_BITS-1:0] pend_start, pend_start_next;
  logic [LINE_BITS-1:0]     pend_line, pend_line_next;
  logic [LINE_BITS-1:0]     pend_col, pend_col_next;
  logic [KEYWORD_COUNT-1:0] cand, cand_next;
  logic [7:0]               pend_op, pend_op_next;
  logic [POSITION_BITS-1:0] pend_len, pend_len_next;
  logic                     note_pre, note_pre_next;
  logic [POSITION_BITS-1:0] dot_pos, dot_pos_next;
  logic [LINE_BITS-1:0]     dot_col, dot_col_next;

  // token queue
  tok_t       tq [4];
  logic       tl [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  tok_t       em [MAX_TOKENS];
  logic [1:0] n_em;
  logic       in_fire, pop;
  logic       do_flush, rescan, alnum;

  logic                     trk_ident;
  logic [KEYWORD_COUNT-1:0] trk_cand_in, trk_cand;
  logic [3:0]               len_idx;
  logic                     kw_hit;
  logic [4:0]               kw_index;

  assign in_fire = in_valid && in_ready;
  assign pop     = out_valid && out_ready;
  assign in_ready  = count <= 3'd1;
  assign out_valid = count != 3'd0;

  assign alnum     = is_alpha(source_byte) || is_digit(source_byte);
  assign trk_ident = (mode == MODE_IDENT) && alnum;
  assign len_idx   = (pend_len > POSITION_BITS'(15)) ? 4'd15 : pend_len[3:0];
  assign trk_cand_in = trk_ident ? cand : '1;

  sts_keyword_match #(
    .KEYWORD_COUNT(KEYWORD_COUNT)
  ) u_kw (
    .track_cand (trk_cand_in),
    .track_idx  (trk_ident ? len_idx : 4'd0),
    .ch         (source_byte),
    .match_cand (cand),
    .match_len  (len_idx),
    .cand_out   (trk_cand),
    .kw_hit     (kw_hit),
    .kw_index   (kw_index)
  );

  always_comb begin
    mode_next       = mode;
    byte_pos_next   = byte_pos;
    cur_line_next   = cur_line;
    cur_col_next    = cur_col;
    pend_start_next = pend_start;
    pend_line_next  = pend_line;
    pend_col_next   = pend_col;
    cand_next       = cand;
    pend_op_next    = pend_op;
    pend_len_next   = pend_len;
    note_pre_next   = note_pre;
    dot_pos_next    = dot_pos;
    dot_col_next    = dot_col;
    do_flush        = 1'b0;
    rescan          = 1'b0;
    n_em            = 2'd0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      em[i] = '0;
    end

    if (in_fire) begin
      if (end_of_source) begin
        do_flush = 1'b1;
      end else begin
        unique case (mode)
          MODE_IDENT: begin
            if (alnum) begin
              cand_next     = trk_cand;
              note_pre_next = note_pre && (pend_len < POSITION_BITS'(4))
                              && (note_char(pend_len[1:0]) == source_byte);
              pend_len_next = pos_inc(pend_len, 2'd1);
            end else if (source_byte == CH_COLON && note_pre
                         && pend_len == POSITION_BITS'(4)) begin
              mode_next = MODE_COMMENT;
            end else begin
              do_flush = 1'b1;
              rescan   = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (is_digit(source_byte)) begin
              pend_len_next = pos_inc(pend_len, 2'd1);
            end else if (source_byte == CH_DOT) begin
              mode_next    = MODE_NUMDOT;
              dot_pos_next = byte_pos;
              dot_col_next = cur_col;
            end else begin
              do_flush = 1'b1;
              rescan   = 1'b1;
            end
          end
          MODE_NUMDOT: begin
            if (is_digit(source_byte)) begin
              mode_next     = MODE_DECIMAL;
              pend_len_next = pos_inc(pend_len, 2'd2);
            end else begin
              do_flush = 1'b1;
              rescan   = 1'b1;
            end
          end
          MODE_DECIMAL: begin
            if (is_digit(source_byte)) begin
              pend_len_next = pos_inc(pend_len, 2'd1);
            end else begin
              do_flush = 1'b1;
              rescan   = 1'b1;
            end
          end
          MODE_STRING: begin
            pend_len_next = pos_inc(pend_len, 2'd1);
            if (source_byte == CH_QUOTE) begin
              do_flush = 1'b1;
            end
          end
          MODE_OPERATOR: begin
            if (source_byte == CH_EQ) begin
              pend_len_next = POSITION_BITS'(2);
              em[n_em] = mk_tok(pair_kind(pend_op), pend_start, POSITION_BITS'(2),
                                pend_line, pend_col);
              n_em      = n_em + 2'd1;
              mode_next = MODE_IDLE;
            end else begin
              do_flush = 1'b1;
              rescan   = 1'b1;
            end
          end
          MODE_COMMENT: begin
            if (source_byte == CH_NEWLINE) begin
              mode_next = MODE_IDLE;
              rescan    = 1'b1;
            end
          end
          default: begin
            rescan = 1'b1;
          end
        endcase
      end

      // pending token goes out; string length already counts the closing quote
      if (do_flush) begin
        case (mode)
          MODE_IDENT: begin
            em[n_em] = mk_tok(kw_hit ? K_KEYWORD0 + 6'(kw_index) : K_IDENT, pend_start,
                              pend_len_next, pend_line, pend_col);
            n_em = n_em + 2'd1;
          end
          MODE_NUMBER, MODE_NUMDOT: begin
            em[n_em] = mk_tok(K_NUMBER, pend_start, pend_len_next, pend_line, pend_col);
            n_em = n_em + 2'd1;
            if (mode == MODE_NUMDOT) begin
              em[n_em] = mk_tok(K_ERROR, dot_pos, POS_ONE, cur_line, dot_col);
              n_em = n_em + 2'd1;
            end
          end
          MODE_DECIMAL: begin
            em[n_em] = mk_tok(K_DECIMAL, pend_start, pend_len_next, pend_line, pend_col);
            n_em = n_em + 2'd1;
          end
          MODE_STRING: begin
            em[n_em] = mk_tok(K_STRING, pend_start, pend_len_next, pend_line, pend_col);
            n_em = n_em + 2'd1;
          end
          MODE_OPERATOR: begin
            em[n_em] = mk_tok(single_kind(pend_op), pend_start, pend_len_next,
                              pend_line, pend_col);
            n_em = n_em + 2'd1;
          end
          default: begin
          end
        endcase
        mode_next = MODE_IDLE;
      end

      // byte is rescanned: it opens a new token, emits a single-character token or is skipped as blank
      if (rescan) begin
        pend_start_next = byte_pos;
        pend_line_next  = cur_line;
        pend_col_next   = cur_col;
        pend_len_next   = POS_ONE;
        mode_next       = MODE_IDLE;
        if (source_byte == CH_SPACE || source_byte == CH_TAB) begin
          mode_next = MODE_IDLE;
        end else if (source_byte == CH_NEWLINE) begin
          em[n_em] = mk_tok(K_NEWLINE, byte_pos, POS_ONE, cur_line, cur_col);
          n_em = n_em + 2'd1;
        end else if (is_alpha(source_byte)) begin
          mode_next     = MODE_IDENT;
          cand_next     = trk_cand;
          note_pre_next = source_byte == note_char(2'd0);
        end else if (is_digit(source_byte)) begin
          mode_next = MODE_NUMBER;
        end else if (source_byte == CH_QUOTE) begin
          mode_next = MODE_STRING;
        end else if (source_byte == CH_EQ || source_byte == CH_LT
                     || source_byte == CH_GT || source_byte == CH_BANG) begin
          mode_next    = MODE_OPERATOR;
          pend_op_next = source_byte;
        end else begin
          em[n_em] = mk_tok(single_kind(source_byte), byte_pos, POS_ONE, cur_line, cur_col);
          n_em = n_em + 2'd1;
        end
      end

      if (end_of_source) begin
        em[n_em] = mk_tok(K_EOF, byte_pos, '0, cur_line, cur_col);
        n_em = n_em + 2'd1;
        mode_next       = MODE_IDLE;
        byte_pos_next   = '0;
        cur_line_next   = LINE_ONE;
        cur_col_next    = LINE_ONE;
        pend_start_next = '0;
        pend_line_next  = LINE_ONE;
        pend_col_next   = LINE_ONE;
        cand_next       = '1;
        pend_op_next    = '0;
        pend_len_next   = '0;
        note_pre_next   = 1'b0;
        dot_pos_next    = '0;
        dot_col_next    = LINE_ONE;
      end else begin
        if (source_byte == CH_NEWLINE) begin
          cur_line_next = line_inc(cur_line);
          cur_col_next  = LINE_ONE;
        end else begin
          cur_col_next = line_inc(cur_col);
        end
        byte_pos_next = pos_inc(byte_pos, 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      byte_pos   <= '0;
      cur_line   <= LINE_ONE;
      cur_col    <= LINE_ONE;
      pend_start <= '0;
      pend_line  <= LINE_ONE;
      pend_col   <= LINE_ONE;
      cand       <= '1;
      pend_op    <= '0;
      pend_len   <= '0;
      note_pre   <= 1'b0;
      dot_pos    <= '0;
      dot_col    <= LINE_ONE;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      mode       <= mode_next;
      byte_pos   <= byte_pos_next;
      cur_line   <= cur_line_next;
      cur_col    <= cur_col_next;
      pend_start <= pend_start_next;
      pend_line  <= pend_line_next;
      pend_col   <= pend_col_next;
      cand       <= cand_next;
      pend_op    <= pend_op_next;
      pend_len   <= pend_len_next;
      note_pre   <= note_pre_next;
      dot_pos    <= dot_pos_next;
      dot_col    <= dot_col_next;
      wr_ptr     <= wr_ptr + n_em;
      rd_ptr     <= rd_ptr + 2'(pop);
      count      <= count + 3'(n_em) - 3'(pop);
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (2'(i) < n_em) begin
        tq[wr_ptr + 2'(i)] <= em[i];
        tl[wr_ptr + 2'(i)] <= (2'(i) == n_em - 2'd1);
      end
    end
  end

  assign token_kind   = tq[rd_ptr].kind;
  assign token_start  = tq[rd_ptr].start;
  assign token_length = tq[rd_ptr].len;
  assign token_line   = tq[rd_ptr].line;
  assign token_column = tq[rd_ptr].col;
  assign last_of_run  = tl[rd_ptr];

endmodule

// ===== rtl/core/sts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks on the token scanner, bound to source_token_scanner_unit.
// ----------------------------------------------------------------------------
module sts_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] token_kind,
  input logic       token_length_zero,
  input logic       last_of_run
);
  import sts_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind))
    else $error("token changed while stalled");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == K_EOF |-> last_of_run)
    else $error("eof is not last of its run");

  a_eof_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == K_EOF |-> token_length_zero)
    else $error("eof with nonzero length");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= K_ERROR)
    else $error("token kind out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind source_token_scanner_unit sts_checker u_sts_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .token_kind        (token_kind),
  .token_length_zero (token_length == '0),
  .last_of_run       (last_of_run)
);
